// File: src/waypoint_arrival_sequencer_assert.svh
// assertion macros for the waypoint arrival sequencer
// depends on nothing; included by the top level after its logic
`ifndef WAYPOINT_ARRIVAL_SEQUENCER_ASSERT_SVH
`define WAYPOINT_ARRIVAL_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// check a property on the rising clock edge, held off during reset
`define WAS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("waypoint sequencer check failed at %m");

// check a property on every rising clock edge, reset included
`define WAS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("waypoint sequencer check failed at %m");

`else

`define WAS_ASSERT(lbl, clk, rst, prop)
`define WAS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: src/wpa_pkg.sv
// shared types and constants for the waypoint arrival sequencer
// no dependencies; used by wpa_ram users and the top level
package wpa_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int POS_W   = 24;
  localparam int ANG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;

  // request kinds
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_POSE   = 1'b1;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_XY_RADIUS   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_Z_BOUND     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_YAW_THRESH  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_WAIT_TIME   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PUB_PERIOD  = 3'd4;

  // register reset values
  localparam logic [15:0]       XY_RADIUS_RST  = 16'd500;
  localparam logic [31:0]       XY_RADIUS2_RST = 32'd250000;
  localparam logic [15:0]       Z_BOUND_RST    = 16'd5000;
  localparam logic [14:0]       YAW_THRESH_RST = 15'd1820;
  localparam logic [TIME_W-1:0] WAIT_TIME_RST  = '0;
  localparam logic [15:0]       PUB_PERIOD_RST = 16'd200;

  // one stored waypoint
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [ANG_W-1:0]        yaw;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: src/wpa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and read-first registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/waypoint_arrival_sequencer.sv
// waypoint arrival sequencer top level: table, arrival test, dwell and publish timing
// depends on wpa_pkg, wpa_ram and waypoint_arrival_sequencer_assert.svh
//
//  channel   | strobe  | payload                                   | flow
//  ----------+---------+-------------------------------------------+---------------------
//  request   | start   | action pos_x pos_y pos_z heading stamp_ms | taken when !busy
//  result    | done    | publish target_* target_index             | one cycle, no stall
//            |         | waypoint_count target_active append_dropped |
//  config    | cfg_we  | cfg_index cfg_data                        | written at once
//
// one request per cycle; its result shows in the following cycle, with done high for that cycle.
// busy stays low: the current target lives in registers and the next entry of the table
// is prefetched from the ram, so an advance never waits on a ram read.
// reset clears the control state but for the current target entry, and the register file; the table is not cleared.
// the receiver cannot stall the result.
module waypoint_arrival_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic signed [wpa_pkg::POS_W-1:0]    pos_x,
  input  logic signed [wpa_pkg::POS_W-1:0]    pos_y,
  input  logic signed [wpa_pkg::POS_W-1:0]    pos_z,
  input  logic [wpa_pkg::ANG_W-1:0]           heading,
  input  logic [wpa_pkg::TIME_W-1:0]          stamp_ms,
  // configuration
  input  logic                                cfg_we,
  input  logic [wpa_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [wpa_pkg::CFG_W-1:0]           cfg_data,
  // result
  output logic                                done,
  output logic                                publish,
  output logic signed [wpa_pkg::POS_W-1:0]    target_x,
  output logic signed [wpa_pkg::POS_W-1:0]    target_y,
  output logic signed [wpa_pkg::POS_W-1:0]    target_z,
  output logic [wpa_pkg::ANG_W-1:0]           target_heading,
  output logic [wpa_pkg::IDX_W-1:0]           target_index,
  output logic [wpa_pkg::CNT_W-1:0]           waypoint_count,
  output logic                                target_active,
  output logic                                append_dropped
);

  localparam int IDX_W  = wpa_pkg::IDX_W;
  localparam int CNT_W  = wpa_pkg::CNT_W;
  localparam int POS_W  = wpa_pkg::POS_W;
  localparam int ANG_W  = wpa_pkg::ANG_W;
  localparam int TIME_W = wpa_pkg::TIME_W;

  // configuration registers
  logic [15:0]       xy_radius2_lo;
  logic [31:0]       xy_radius2;
  logic [15:0]       z_bound;
  logic [14:0]       yaw_thresh;
  logic [TIME_W-1:0] wait_time;
  logic [15:0]       pub_period;

  // control state
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  cur_index;
  logic              waiting;
  logic [TIME_W-1:0] wait_start;
  logic [TIME_W-1:0] last_pub;
  wpa_pkg::entry_t   cur_entry;
  logic              byp_valid;
  wpa_pkg::entry_t   byp_entry;

  // next values
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  cur_index_next;
  logic              waiting_next;
  logic [TIME_W-1:0] wait_start_next;
  logic [TIME_W-1:0] last_pub_next;
  wpa_pkg::entry_t   cur_entry_next;
  logic              publish_next;
  logic              dropped_next;

  logic              accept;
  logic              do_append;
  logic              do_pose;
  wpa_pkg::entry_t   in_entry;
  wpa_pkg::entry_t   ram_rd_data;
  wpa_pkg::entry_t   next_entry;
  logic [IDX_W-1:0]  rd_addr;

  // arrival test signals
  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic signed [POS_W:0]   dz;
  logic [POS_W:0]          dx_mag;
  logic [POS_W:0]          dy_mag;
  logic [POS_W:0]          dz_mag;
  logic [2*POS_W-1:0]      sq_x;
  logic [2*POS_W-1:0]      sq_y;
  logic [2*POS_W:0]        dist2;
  logic [ANG_W-1:0]        yaw_diff;
  logic [ANG_W-1:0]        yaw_mag;
  logic                    arrived;
  logic                    wait_over;
  logic                    pub_due;
  logic                    waiting_mid;
  logic [TIME_W-1:0]       wait_start_mid;
  logic                    has_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign do_append = accept && (action == wpa_pkg::ACT_APPEND);
  assign do_pose   = accept && (action == wpa_pkg::ACT_POSE) && (count != '0);

  assign in_entry.x   = pos_x;
  assign in_entry.y   = pos_y;
  assign in_entry.z   = pos_z;
  assign in_entry.yaw = heading;

  // configuration writes; radius is kept squared for the xy compare
  assign xy_radius2_lo = cfg_data[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_radius2 <= wpa_pkg::XY_RADIUS2_RST;
      z_bound    <= wpa_pkg::Z_BOUND_RST;
      yaw_thresh <= wpa_pkg::YAW_THRESH_RST;
      wait_time  <= wpa_pkg::WAIT_TIME_RST;
      pub_period <= wpa_pkg::PUB_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpa_pkg::REG_XY_RADIUS:  xy_radius2 <= 32'(xy_radius2_lo) * 32'(xy_radius2_lo);
        wpa_pkg::REG_Z_BOUND:    z_bound    <= cfg_data[15:0];
        wpa_pkg::REG_YAW_THRESH: yaw_thresh <= cfg_data[14:0];
        wpa_pkg::REG_WAIT_TIME:  wait_time  <= cfg_data[TIME_W-1:0];
        wpa_pkg::REG_PUB_PERIOD: pub_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // waypoint table; the read port always fetches the entry after the target
  assign rd_addr = cur_index_next + IDX_W'(1);

  wpa_ram #(
    .WIDTH (wpa_pkg::ENTRY_W),
    .DEPTH (wpa_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (do_append && !dropped_next),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (in_entry),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // forward an entry written in the same cycle it is fetched
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= do_append && !dropped_next && (count[IDX_W-1:0] == rd_addr);
    end
    byp_entry <= in_entry;
  end

  assign next_entry = byp_valid ? byp_entry : ram_rd_data;

  // distance, height and yaw checks against the current target
  assign dx = {pos_x[POS_W-1], pos_x} - {cur_entry.x[POS_W-1], cur_entry.x};
  assign dy = {pos_y[POS_W-1], pos_y} - {cur_entry.y[POS_W-1], cur_entry.y};
  assign dz = {pos_z[POS_W-1], pos_z} - {cur_entry.z[POS_W-1], cur_entry.z};

  assign dx_mag = dx[POS_W] ? (~dx + (POS_W+1)'(1)) : dx;
  assign dy_mag = dy[POS_W] ? (~dy + (POS_W+1)'(1)) : dy;
  assign dz_mag = dz[POS_W] ? (~dz + (POS_W+1)'(1)) : dz;

  assign sq_x  = (2*POS_W)'(dx_mag[POS_W-1:0]) * (2*POS_W)'(dx_mag[POS_W-1:0]);
  assign sq_y  = (2*POS_W)'(dy_mag[POS_W-1:0]) * (2*POS_W)'(dy_mag[POS_W-1:0]);
  assign dist2 = (2*POS_W+1)'(sq_x) + (2*POS_W+1)'(sq_y);

  assign yaw_diff = cur_entry.yaw - heading;
  assign yaw_mag  = yaw_diff[ANG_W-1] ? (~yaw_diff + ANG_W'(1)) : yaw_diff;

  assign arrived = (dist2 < (2*POS_W+1)'(xy_radius2))
                && (dz_mag < (POS_W+1)'(z_bound))
                && (yaw_mag < ANG_W'(yaw_thresh))
                && !waiting;

  // dwell and publish timing
  assign waiting_mid    = waiting || arrived;
  assign wait_start_mid = arrived ? stamp_ms : wait_start;
  assign has_next       = (CNT_W'(cur_index) + CNT_W'(1)) < count;
  assign wait_over      = waiting_mid && ((stamp_ms - wait_start_mid) > wait_time) && has_next;
  assign pub_due        = (stamp_ms - last_pub) > TIME_W'(pub_period);

  // next state for one request
  always_comb begin
    count_next      = count;
    cur_index_next  = cur_index;
    waiting_next    = waiting;
    wait_start_next = wait_start;
    last_pub_next   = last_pub;
    cur_entry_next  = cur_entry;
    publish_next    = 1'b0;
    dropped_next    = 1'b0;
    if (do_append) begin
      if (count < CNT_W'(wpa_pkg::TABLE_DEPTH)) begin
        count_next = count + CNT_W'(1);
        if (count == '0) begin
          cur_entry_next = in_entry;
        end
      end else begin
        dropped_next = 1'b1;
      end
    end else if (do_pose) begin
      waiting_next    = waiting_mid;
      wait_start_next = wait_start_mid;
      if (wait_over) begin
        cur_index_next = cur_index + IDX_W'(1);
        cur_entry_next = next_entry;
        waiting_next   = 1'b0;
      end
      if (pub_due) begin
        publish_next  = !waiting_next;
        last_pub_next = stamp_ms;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cur_index  <= '0;
      waiting    <= 1'b0;
      wait_start <= '0;
      last_pub   <= '0;
    end else begin
      count      <= count_next;
      cur_index  <= cur_index_next;
      waiting    <= waiting_next;
      wait_start <= wait_start_next;
      last_pub   <= last_pub_next;
    end
    cur_entry <= cur_entry_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      publish        <= 1'b0;
      target_index   <= '0;
      waypoint_count <= '0;
      target_active  <= 1'b0;
      append_dropped <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        publish        <= publish_next;
        waypoint_count <= count_next;
        append_dropped <= dropped_next;
        target_index   <= (count_next != '0) ? cur_index_next : '0;
        target_active  <= (count_next != '0) && !waiting_next;
      end
    end
    if (accept) begin
      if (count_next != '0) begin
        target_x       <= cur_entry_next.x;
        target_y       <= cur_entry_next.y;
        target_z       <= cur_entry_next.z;
        target_heading <= cur_entry_next.yaw;
      end else begin
        target_x       <= '0;
        target_y       <= '0;
        target_z       <= '0;
        target_heading <= '0;
      end
    end
  end

  // checks
`include "waypoint_arrival_sequencer_assert.svh"

  `WAS_ASSERT(a_result_follows, clk, rst, accept |=> done)
  `WAS_ASSERT(a_index_in_table, clk, rst, (waypoint_count != '0) |-> (CNT_W'(target_index) < waypoint_count))
  `WAS_ASSERT(a_active_needs_table, clk, rst, target_active |-> (waypoint_count != '0))
  `WAS_ASSERT_ALWAYS(a_publish_not_waiting, clk, publish |-> target_active)

endmodule
